// File: sv/jmsf_pkg.sv
// Shared types and constants for the JPEG metadata segment filter.
// Holds the result kinds, the result record and the parser-to-queue push record.
// No dependencies.
package jmsf_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int FIFO_DEPTH_DEF  = 8;
    localparam int SPAN_BITS       = 32;

    typedef enum logic [2:0] {
        KIND_SPAN      = 3'd0,
        KIND_OK        = 3'd1,
        KIND_MALFORMED = 3'd2,
        KIND_TRUNCATED = 3'd3,
        KIND_PASS      = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [SPAN_BITS-1:0]  span_start;
        logic [SPAN_BITS-1:0]  span_length;
        logic                  final_result;
    } t_result;

    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        t_result first;
        t_result second;
    } t_push;

endpackage

// File: sv/jmsf_if.sv
// Stream interfaces for the JPEG metadata segment filter: byte input and result output.
// Depends on jmsf_pkg.
interface jmsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface jmsf_out_if import jmsf_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [2:0]           kind;
    logic [SPAN_BITS-1:0] span_start;
    logic [SPAN_BITS-1:0] span_length;
    logic                 final_result;

    modport source (output valid, output kind, output span_start, output span_length,
                    output final_result, input ready);
    modport sink (input valid, input kind, input span_start, input span_length,
                  input final_result, output ready);
endinterface

// File: sv/jmsf_parser.sv
// Marker segment parser: updates the parse state for one byte per cycle and
// produces up to two results (a kept span and the end-of-file status).
// Depends on jmsf_pkg.
module jmsf_parser import jmsf_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    input  logic       i_strip_enable,
    output t_push      o_push
);

    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_APP2 = 8'hE2;
    localparam logic [7:0] MK_APPE = 8'hEE;
    localparam logic [7:0] MK_APPF = 8'hEF;
    localparam logic [7:0] MK_COM  = 8'hFE;
    localparam logic [3:0] TAG_LEN = 4'd12;

    typedef enum logic [3:0] {
        PH_SOI0, PH_SOI1, PH_MARK_FF, PH_MARK_CODE, PH_LEN_HI, PH_LEN_LO,
        PH_PAYLOAD, PH_SCAN, PH_NONJPEG, PH_MALFORMED
    } t_phase;

    function automatic logic [7:0] icc_tag(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "I";
            4'd1:    c = "C";
            4'd2:    c = "C";
            4'd3:    c = "_";
            4'd4:    c = "P";
            4'd5:    c = "R";
            4'd6:    c = "O";
            4'd7:    c = "F";
            4'd8:    c = "I";
            4'd9:    c = "L";
            4'd10:   c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic keep_segment(input logic [7:0] m, input logic [3:0] idx,
                                          input logic mis);
        logic k;
        if (m == MK_APP0 || m == MK_APPE) begin
            k = 1'b1;
        end else if (m == MK_APP2) begin
            k = (idx >= TAG_LEN) && !mis;
        end else if (m == MK_COM) begin
            k = 1'b0;
        end else begin
            k = (m < MK_APP0) || (m > MK_APPF);
        end
        return k;
    endfunction

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_seg_start, n_seg_start;
    logic [7:0]             r_marker, n_marker;
    logic [15:0]            r_seg_len, n_seg_len;
    logic [15:0]            r_remain, n_remain;
    logic [3:0]             r_match_idx, n_match_idx;
    logic                   r_mismatch, n_mismatch;
    logic                   r_too_long, n_too_long;

    logic                   at_max;
    logic                   too_long;
    logic [OFFSET_BITS-1:0] seg_len_to_pos;
    logic                   span_valid;
    logic [OFFSET_BITS-1:0] span_start;
    logic [OFFSET_BITS-1:0] span_length;
    logic                   status_valid;
    t_kind                  status_kind;
    logic                   standalone;
    t_result                span_res;
    t_result                status_res;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_seg_start  = r_seg_start;
        n_marker     = r_marker;
        n_seg_len    = r_seg_len;
        n_remain     = r_remain;
        n_match_idx  = r_match_idx;
        n_mismatch   = r_mismatch;
        n_too_long   = r_too_long;
        span_valid   = 1'b0;
        span_start   = r_seg_start;
        span_length  = '0;
        status_valid = 1'b0;
        status_kind  = KIND_TRUNCATED;
        at_max       = &r_pos;
        too_long     = r_too_long || at_max;
        seg_len_to_pos = r_pos + OFFSET_BITS'(1) - r_seg_start;
        standalone   = (i_byte == MK_SOI) || (i_byte == MK_TEM)
                       || ((i_byte >= MK_RST0) && (i_byte <= MK_RST7));

        if (i_valid) begin
            n_too_long = too_long;
            unique case (r_phase)
                PH_SOI0: begin
                    n_phase = (i_byte == MK_FILL) ? PH_SOI1 : PH_NONJPEG;
                end
                PH_SOI1: begin
                    if (i_byte == MK_SOI) begin
                        if (!i_eof && i_strip_enable) begin
                            span_valid  = 1'b1;
                            span_start  = '0;
                            span_length = OFFSET_BITS'(2);
                        end
                        n_phase = PH_MARK_FF;
                    end else begin
                        n_phase = PH_NONJPEG;
                    end
                end
                PH_MARK_FF: begin
                    if (i_byte == MK_FILL) begin
                        n_seg_start = r_pos;
                        n_phase     = PH_MARK_CODE;
                    end else if (!i_eof) begin
                        n_phase = PH_MALFORMED;
                    end
                end
                PH_MARK_CODE: begin
                    if (i_byte != MK_FILL) begin
                        n_marker = i_byte;
                        if (standalone) begin
                            span_valid  = i_strip_enable;
                            span_length = seg_len_to_pos;
                            n_phase     = PH_MARK_FF;
                        end else if (i_byte == MK_SOS || i_byte == MK_EOI) begin
                            n_phase = PH_SCAN;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI: begin
                    n_seg_len = {i_byte, 8'h00};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_seg_len = {r_seg_len[15:8], i_byte};
                    if (n_seg_len < 16'd2) begin
                        n_phase = PH_MALFORMED;
                    end else begin
                        n_remain    = n_seg_len - 16'd2;
                        n_match_idx = '0;
                        n_mismatch  = 1'b0;
                        if (n_remain == 16'd0) begin
                            span_valid  = i_strip_enable
                                          && keep_segment(r_marker, n_match_idx, n_mismatch);
                            span_length = seg_len_to_pos;
                            n_phase     = PH_MARK_FF;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_match_idx < TAG_LEN) begin
                        n_mismatch  = r_mismatch || (i_byte != icc_tag(r_match_idx));
                        n_match_idx = r_match_idx + 4'd1;
                    end
                    n_remain = r_remain - 16'd1;
                    if (n_remain == 16'd0) begin
                        span_valid  = i_strip_enable
                                      && keep_segment(r_marker, n_match_idx, n_mismatch);
                        span_length = seg_len_to_pos;
                        n_phase     = PH_MARK_FF;
                    end
                end
                PH_SCAN, PH_NONJPEG, PH_MALFORMED: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_NONJPEG;
                end
            endcase

            if (i_eof) begin
                status_valid = 1'b1;
                if (!i_strip_enable || too_long || (r_pos < OFFSET_BITS'(3))
                    || n_phase == PH_NONJPEG) begin
                    status_kind = KIND_PASS;
                end else if (n_phase == PH_MALFORMED) begin
                    status_kind = KIND_MALFORMED;
                end else if (n_phase == PH_SCAN) begin
                    span_valid  = 1'b1;
                    span_length = seg_len_to_pos;
                    status_kind = KIND_OK;
                end else begin
                    status_kind = KIND_TRUNCATED;
                end
                n_phase     = PH_SOI0;
                n_pos       = '0;
                n_seg_start = '0;
                n_marker    = '0;
                n_seg_len   = '0;
                n_remain    = '0;
                n_match_idx = '0;
                n_mismatch  = 1'b0;
                n_too_long  = 1'b0;
            end else begin
                n_pos = at_max ? r_pos : r_pos + OFFSET_BITS'(1);
            end
        end
    end

    always_comb begin
        span_res.kind          = KIND_SPAN;
        span_res.span_start    = SPAN_BITS'(span_start);
        span_res.span_length   = SPAN_BITS'(span_length);
        span_res.final_result  = 1'b0;
        status_res.kind        = status_kind;
        status_res.span_start  = '0;
        status_res.span_length = '0;
        status_res.final_result = 1'b1;
        o_push.first_valid  = span_valid || status_valid;
        o_push.second_valid = span_valid && status_valid;
        o_push.first        = span_valid ? span_res : status_res;
        o_push.second       = status_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOI0;
            r_pos       <= '0;
            r_seg_start <= '0;
            r_marker    <= '0;
            r_seg_len   <= '0;
            r_remain    <= '0;
            r_match_idx <= '0;
            r_mismatch  <= 1'b0;
            r_too_long  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_seg_start <= n_seg_start;
            r_marker    <= n_marker;
            r_seg_len   <= n_seg_len;
            r_remain    <= n_remain;
            r_match_idx <= n_match_idx;
            r_mismatch  <= n_mismatch;
            r_too_long  <= n_too_long;
        end
    end

endmodule

// File: sv/jmsf_result_fifo.sv
// Result queue: takes up to two results per cycle and hands one per request
// to the output channel.
// Depends on jmsf_pkg and jmsf_out_if.
module jmsf_result_fifo import jmsf_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    parameter int LVL_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic [LVL_W-1:0] o_level,
    jmsf_out_if.source       o_out
);

    localparam int PTR_W = $clog2(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0] r_level, n_level;
    logic [PTR_W-1:0] wr_ptr_next;
    logic             pop;
    t_result          head;

    always_comb begin
        pop         = o_out.valid && o_out.ready;
        wr_ptr_next = ptr_inc(r_wr_ptr);
        n_wr_ptr    = r_wr_ptr;
        if (i_push.second_valid) begin
            n_wr_ptr = ptr_inc(wr_ptr_next);
        end else if (i_push.first_valid) begin
            n_wr_ptr = wr_ptr_next;
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_level  = r_level + LVL_W'(i_push.first_valid) + LVL_W'(i_push.second_valid)
                   - LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    assign head               = r_mem[r_rd_ptr];
    assign o_level            = r_level;
    assign o_out.valid        = (r_level != '0);
    assign o_out.kind         = head.kind;
    assign o_out.span_start   = head.span_start;
    assign o_out.span_length  = head.span_length;
    assign o_out.final_result = head.final_result;

endmodule

// File: sv/jpeg_metadata_segment_filter.sv
// An accepted byte is registered at the input; its results are written to the queue, then offered.
// Throughput: one byte per cycle; a byte may cause two results, which drain through
// the result queue at one per cycle while the output is ready, and input is held off
// while fewer than four queue entries are free.
// Reset: synchronous, active low; clears the parse state and queue, strip_enable
// returns to 1.
module jpeg_metadata_segment_filter import jmsf_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jmsf_in_if.sink     i_in,
    jmsf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    logic             r_strip_enable;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eof;
    logic [LVL_W-1:0] level;
    logic             accept;
    logic             cfg_write;
    t_push            push;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = paddr[2] ? 32'd0 : {31'd0, r_strip_enable};

    assign i_in.ready = (level <= LVL_W'(FIFO_DEPTH - 4));
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_enable <= 1'b1;
            r_in_valid     <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_strip_enable <= pwdata[0];
            end
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_eof  <= i_in.end_of_file;
        end
    end

    jmsf_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_byte         (r_in_byte),
        .i_eof          (r_in_eof),
        .i_strip_enable (r_strip_enable),
        .o_push         (push)
    );

    jmsf_result_fifo #(
        .DEPTH (FIFO_DEPTH),
        .LVL_W (LVL_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_level (level),
        .o_out   (o_out)
    );

endmodule
